### design/pmpd_pkg.sv
// ----------------------------------------------------------------------------
// pmpd_pkg
// Shared constants, frame layout and helpers of the power monitor decoder.
// ----------------------------------------------------------------------------
package pmpd_pkg;

	localparam int FRAME_BYTES = 11;
	localparam int POS_W       = $clog2(FRAME_BYTES);

	localparam logic [7:0] SYNC_BYTE = 8'h55;

	// byte offsets inside a frame
	localparam int ADDR_INDEX  = 1;
	localparam int COUNT_INDEX = 2;
	localparam int POWER_INDEX = 3;
	localparam int VOLT_INDEX  = 6;
	localparam int SUM_INDEX   = 9;

	localparam logic signed [16:0] VOLT_OFFSET = 17'sd27620;
	localparam logic signed [23:0] WATT_MUL    = 24'sd70;
	localparam logic signed [12:0] VOLT_BASE   = 13'sd1236;

	// reciprocals for exact truncating division of bounded magnitudes
	localparam logic [22:0] DIV17_M = 23'd7895161;
	localparam int          DIV17_K = 27;
	localparam logic [16:0] DIV85_M = 17'd98690;
	localparam int          DIV85_K = 23;
	localparam logic [11:0] DIV10_M = 12'd3277;
	localparam int          DIV10_K = 15;

	typedef struct packed {
		logic               bad;
		logic [7:0]         addr;
		logic [7:0]         count;
		logic signed [15:0] power;
		logic signed [15:0] volt_raw;
	} frame_t;

	// signed 24-bit value divided by 256, truncating toward zero
	function automatic logic signed [15:0] trunc256(input logic [23:0] v);
		logic round_up;
		round_up = v[23] && (v[7:0] != 8'd0);
		return v[23:8] + {15'd0, round_up};
	endfunction

endpackage

### design/pmpd_if.sv
// ----------------------------------------------------------------------------
// pmpd_if
// Valid/ready channels of the power monitor decoder: raw bytes and results.
// ----------------------------------------------------------------------------
interface pmpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;

	modport source(output valid, output line_byte, input ready);
	modport sink(input valid, input line_byte, output ready);
endinterface

interface pmpd_result_if;
	logic               valid;
	logic               ready;
	logic               frame_status;
	logic [7:0]         sensor_address;
	logic [7:0]         sample_count;
	logic signed [18:0] power_watts;
	logic signed [8:0]  line_volts;

	modport source(output valid, output frame_status, output sensor_address,
		output sample_count, output power_watts, output line_volts, input ready);
	modport sink(input valid, input frame_status, input sensor_address,
		input sample_count, input power_watts, input line_volts, output ready);
endinterface

### design/pmpd_conv.sv
// ----------------------------------------------------------------------------
// pmpd_conv
// Scales a captured frame into watts and volts over three register stages.
// ----------------------------------------------------------------------------
module pmpd_conv
	import pmpd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  frame_t         in_frame,
	pmpd_result_if.source  result
);

	logic load_s2, load_s3, load_o;
	logic v_s2, v_s3, v_q;

	assign load_o   = !v_q || result.ready;
	assign load_s3  = !v_s3 || load_o;
	assign load_s2  = !v_s2 || load_s3;
	assign in_ready = load_s2;

	// stage 2: 70*(p+1) and v/256-27620 as sign and magnitude
	logic signed [16:0] p_inc;
	logic signed [23:0] x_prod, x_abs;
	logic signed [16:0] y_val, y_abs;

	assign p_inc  = {in_frame.power[15], in_frame.power} + 17'sd1;
	assign x_prod = 24'(p_inc) * WATT_MUL;
	assign x_abs  = x_prod[23] ? -x_prod : x_prod;
	assign y_val  = {in_frame.volt_raw[15], in_frame.volt_raw} - VOLT_OFFSET;
	assign y_abs  = y_val[16] ? -y_val : y_val;

	logic        bad_s2, xneg_s2, yneg_s2;
	logic [7:0]  addr_s2, count_s2;
	logic [21:0] xmag_s2;
	logic [15:0] ymag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && in_valid) begin
			bad_s2   <= in_frame.bad;
			addr_s2  <= in_frame.addr;
			count_s2 <= in_frame.count;
			xneg_s2  <= x_prod[23];
			xmag_s2  <= x_abs[21:0];
			yneg_s2  <= y_val[16];
			ymag_s2  <= y_abs[15:0];
		end
	end

	// stage 3: divide by 17 and by 85
	logic [44:0]        w_prod;
	logic [17:0]        w_mag;
	logic [32:0]        q_prod;
	logic [9:0]         q_mag;
	logic signed [18:0] watts;
	logic signed [10:0] q_val;

	assign w_prod = 45'(xmag_s2) * 45'(DIV17_M);
	assign w_mag  = w_prod[DIV17_K +: 18];
	assign watts  = xneg_s2 ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
	assign q_prod = 33'(ymag_s2) * 33'(DIV85_M);
	assign q_mag  = q_prod[DIV85_K +: 10];
	assign q_val  = yneg_s2 ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

	logic               bad_s3;
	logic [7:0]         addr_s3, count_s3;
	logic signed [18:0] watts_s3;
	logic signed [10:0] q_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (load_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3 && v_s2) begin
			bad_s3   <= bad_s2;
			addr_s3  <= addr_s2;
			count_s3 <= count_s2;
			watts_s3 <= watts;
			q_s3     <= q_val;
		end
	end

	// output stage: (1236 + 4q) / 10
	logic signed [12:0] z_val, z_abs;
	logic [22:0]        v_prod;
	logic [7:0]         v_mag;
	logic signed [8:0]  volts;

	assign z_val  = VOLT_BASE + {q_s3[10], q_s3, 1'b0} + {q_s3[10], q_s3, 1'b0};
	assign z_abs  = z_val[12] ? -z_val : z_val;
	assign v_prod = 23'(z_abs[10:0]) * 23'(DIV10_M);
	assign v_mag  = v_prod[DIV10_K +: 8];
	assign volts  = z_val[12] ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});

	logic               status_q;
	logic [7:0]         addr_q, count_q;
	logic signed [18:0] watts_q;
	logic signed [8:0]  volts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load_o) begin
			v_q <= v_s3;
		end
	end

	// a bad checksum leaves only the status bit
	always_ff @(posedge clk) begin
		if (load_o && v_s3) begin
			status_q <= bad_s3;
			addr_q   <= bad_s3 ? 8'd0 : addr_s3;
			count_q  <= bad_s3 ? 8'd0 : count_s3;
			watts_q  <= bad_s3 ? 19'sd0 : watts_s3;
			volts_q  <= bad_s3 ? 9'sd0 : volts;
		end
	end

	assign result.valid          = v_q;
	assign result.frame_status   = status_q;
	assign result.sensor_address = addr_q;
	assign result.sample_count   = count_q;
	assign result.power_watts    = watts_q;
	assign result.line_volts     = volts_q;

	a_bad_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && status_q |-> addr_q == 8'd0 && count_q == 8'd0 &&
			watts_q == 19'sd0 && volts_q == 9'sd0)
		else $error("bad frame result carries nonzero fields");

	a_volts_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> volts_q >= -9'sd160 && volts_q <= 9'sd147)
		else $error("line volts outside range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !result.ready |=> v_q && $stable(watts_q) && $stable(volts_q))
		else $error("stalled result changed");

endmodule

### design/power_monitor_packet_decoder.sv
// ----------------------------------------------------------------------------
// power_monitor_packet_decoder
// Resyncs on the inverted sync byte, gathers eleven-byte frames, checks the
// byte sum and reports address, count, watts and volts per frame.
// ----------------------------------------------------------------------------
//  port     dir   item                         payload
//  line     in    one raw serial byte          line_byte
//  result   out   one decoded frame            frame_status, sensor_address,
//                                              sample_count, power_watts,
//                                              line_volts
//
//  one byte is taken every cycle while line.ready is high; the framer works
//  on it in that cycle; the closing byte of a frame reaches the result
//  through four registers (capture, scale, divide, output register)
//  a stalled result backs up the four stages; line.ready falls only when
//  the frame capture register is full and cannot move on
//  reset puts the framer into sync hunting and empties every stage
// ----------------------------------------------------------------------------
module power_monitor_packet_decoder
	import pmpd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pmpd_byte_if.sink     line,
	pmpd_result_if.source result
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       frame_q [ADDR_INDEX:SUM_INDEX];

	logic       load_s1, conv_ready, accept, hunting, take, last;
	logic [7:0] c, sum_next;
	frame_t     cap;

	assign c        = ~line.line_byte;
	assign accept   = line.valid && line.ready;
	assign hunting  = (pos_q == '0) && (c != SYNC_BYTE);
	assign take     = accept && !hunting;
	assign last     = pos_q == POS_W'(FRAME_BYTES - 1);
	assign sum_next = sum_q + c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= 8'd0;
		end else if (take) begin
			if (last) begin
				pos_q <= '0;
				sum_q <= 8'd0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= sum_next;
			end
		end
	end

	// only the bytes that feed a result are kept
	always_ff @(posedge clk) begin
		if (take && pos_q >= POS_W'(ADDR_INDEX) && pos_q <= POS_W'(SUM_INDEX)) begin
			frame_q[pos_q] <= c;
		end
	end

	assign cap.bad      = sum_next != frame_q[SUM_INDEX];
	assign cap.addr     = frame_q[ADDR_INDEX];
	assign cap.count    = frame_q[COUNT_INDEX];
	assign cap.power    = trunc256({frame_q[POWER_INDEX + 2], frame_q[POWER_INDEX + 1],
		frame_q[POWER_INDEX]});
	assign cap.volt_raw = trunc256({frame_q[VOLT_INDEX + 2], frame_q[VOLT_INDEX + 1],
		frame_q[VOLT_INDEX]});

	logic   v_s1;
	frame_t frm_s1;

	assign load_s1    = !v_s1 || conv_ready;
	assign line.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= take && last;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			frm_s1 <= cap;
		end
	end

	pmpd_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_ready (conv_ready),
		.in_frame (frm_s1),
		.result   (result)
	);

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(FRAME_BYTES - 1))
		else $error("byte position past frame end");

	a_hunt_stays: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hunting |=> pos_q == '0 && sum_q == 8'd0)
		else $error("non-sync byte opened a frame");

	a_capture_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(last) && $past(take))
		else $error("frame captured away from its last byte");

	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> pos_q == '0 && sum_q == 8'd0)
		else $error("framer did not return to hunting");

endmodule

### bench/pmpd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpd_frame_checker
// Watches the byte and result channels of the power monitor decoder, frames
// the accepted bytes itself, works out the decoded frame and compares every
// accepted result with the oldest frame still due.
// ----------------------------------------------------------------------------
module pmpd_frame_checker
	import pmpd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	pmpd_byte_if   line,
	pmpd_result_if result,
	output int     fail_count,
	output int     pending
);

	typedef struct packed {
		logic               bad;
		logic [7:0]         addr;
		logic [7:0]         count;
		logic signed [18:0] watts;
		logic signed [8:0]  volts;
	} decoded_frame_t;

	localparam int NUM_FIELDS = 5;

	string field_name [NUM_FIELDS] = '{"frame_status", "sensor_address", "sample_count",
		"power_watts", "line_volts"};

	logic [7:0]     frame_bytes [FRAME_BYTES];
	logic [7:0]     byte_sum = 8'd0;
	int             open_pos = 0;
	int             errors = 0;
	decoded_frame_t frames_due [$];

	always @(posedge clk) begin : watch
		logic [7:0]     c;
		decoded_frame_t want;
		int             p;
		int             q;
		int             w;
		int             v;
		int             want_f [NUM_FIELDS];
		int             got_f [NUM_FIELDS];

		if (arst_n && line.valid && line.ready) begin
			c = ~line.line_byte;
			// outside a frame only the sync byte counts
			if (open_pos != 0 || c == SYNC_BYTE) begin
				frame_bytes[open_pos] = c;
				byte_sum = byte_sum + c;
				if (open_pos == FRAME_BYTES - 1) begin
					open_pos = 0;
					want = '0;
					if (byte_sum != frame_bytes[SUM_INDEX]) begin
						want.bad = 1'b1;
					end else begin
						p = $signed({frame_bytes[POWER_INDEX + 2], frame_bytes[POWER_INDEX + 1],
							frame_bytes[POWER_INDEX]});
						p = p / 256;
						w = (70 * (p + 1)) / 17;
						q = $signed({frame_bytes[VOLT_INDEX + 2], frame_bytes[VOLT_INDEX + 1],
							frame_bytes[VOLT_INDEX]});
						q = (q / 256 - 27620) / 85;
						v = (1236 + 4 * q) / 10;
						want.addr  = frame_bytes[ADDR_INDEX];
						want.count = frame_bytes[COUNT_INDEX];
						want.watts = w[18:0];
						want.volts = v[8:0];
					end
					byte_sum = 8'd0;
					frames_due.push_back(want);
				end else begin
					open_pos++;
				end
			end
		end

		if (arst_n && result.valid && result.ready) begin
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t result with no frame due: expected none, actual status %0d addr %0d",
					$time, result.frame_status, result.sensor_address);
			end else begin
				want = frames_due.pop_front();
				want_f = '{want.bad, want.addr, want.count, want.watts, want.volts};
				got_f  = '{result.frame_status, result.sensor_address, result.sample_count,
					result.power_watts, result.line_volts};
				for (int i = 0; i < NUM_FIELDS; i++) begin
					if (want_f[i] != got_f[i]) begin
						errors++;
						$display("%0t %s mismatch: expected %0d, actual %0d",
							$time, field_name[i], want_f[i], got_f[i]);
					end
				end
			end
		end

		pending <= frames_due.size();
		fail_count <= errors;
	end

endmodule

### bench/power_monitor_packet_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_monitor_packet_decoder_tb
// Feeds inverted serial frames to the decoder: a few directed frames at the
// field extremes, then random good, corrupted, cut-off and noisy traffic with
// random gaps on both channels. The frame checker scores every result.
// ----------------------------------------------------------------------------
module power_monitor_packet_decoder_tb
	import pmpd_pkg::*;
();

	localparam int ITEM_TARGET = 1650;
	localparam int DRAIN_EVERY = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;
	int   hold = 0;
	bit   quiet = 1'b0;
	int   frame_pos = 0;
	int   sent_items = 0;
	int   fail_count;
	int   pending;

	pmpd_byte_if   line_ch ();
	pmpd_result_if result_ch ();

	assign result_ch.ready = sink_ready;

	power_monitor_packet_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.result (result_ch)
	);

	pmpd_frame_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.line       (line_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [23:0] pick_field();
		logic [23:0] f;
		case ($urandom_range(0, 9))
			0: f = 24'h800000;
			1: f = 24'h7fffff;
			2: f = 24'h000000;
			3: f = 24'hffffff;
			4: f = {16'h0000, 8'($urandom)};
			5: f = {16'hffff, 8'($urandom)};
			// around the nominal line voltage
			6: f = 24'h6be400 + 24'($urandom_range(0, 1 << 17)) - 24'(1 << 16);
			default: f = 24'($urandom);
		endcase
		return f;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else if (hold > 0) begin
			hold <= hold - 1;
			sink_ready <= 1'b0;
		end else if (quiet || $urandom_range(0, 3) != 0) begin
			sink_ready <= 1'b1;
		end else begin
			hold <= idle_len();
			sink_ready <= 1'b0;
		end
	end

	task automatic send_byte(input logic [7:0] raw);
		int         gap;
		logic [7:0] inv;
		gap = quiet ? 0 : idle_len();
		inv = ~raw;
		if (gap > 0) begin
			line_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_ch.valid <= 1'b1;
		line_ch.line_byte <= raw;
		@(posedge clk);
		while (!line_ch.ready) @(posedge clk);
		// track framing only to steer the stimulus back into step
		if (frame_pos != 0 || inv == SYNC_BYTE) begin
			sent_items++;
			frame_pos = (frame_pos == FRAME_BYTES - 1) ? 0 : frame_pos + 1;
		end
	endtask

	// bytes are built in decoded form and inverted on the way out
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] count,
		input logic [23:0] pwr, input logic [23:0] volt, input bit corrupt, input int len);
		logic [7:0] fb [FRAME_BYTES];
		logic [7:0] acc;
		fb[0] = SYNC_BYTE;
		fb[ADDR_INDEX] = addr;
		fb[COUNT_INDEX] = count;
		{fb[POWER_INDEX + 2], fb[POWER_INDEX + 1], fb[POWER_INDEX]} = pwr;
		{fb[VOLT_INDEX + 2], fb[VOLT_INDEX + 1], fb[VOLT_INDEX]} = volt;
		fb[SUM_INDEX] = 8'($urandom);
		acc = 8'd0;
		for (int i = 0; i < SUM_INDEX; i++)
			acc = acc + fb[i];
		// the sum byte cancels itself, so the last byte balances the rest
		fb[FRAME_BYTES - 1] = 8'd0 - acc;
		if (corrupt)
			fb[FRAME_BYTES - 1] = fb[FRAME_BYTES - 1] + 8'($urandom_range(1, 255));
		quiet = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++)
			send_byte(~fb[i]);
	endtask

	task automatic drain();
		line_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int kind;
		int frames;
		line_ch.valid <= 1'b0;
		line_ch.line_byte <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// junk while hunting, including the raw sync pattern itself
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(SYNC_BYTE);
		send_frame(8'hff, 8'h00, 24'h800000, 24'h7fffff, 1'b0, FRAME_BYTES);
		// sync byte value inside the frame, then a bad sum
		send_frame(SYNC_BYTE, 8'hff, 24'h7fffff, 24'h800000, 1'b1, FRAME_BYTES);
		drain();

		frames = 0;
		while (sent_items < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				send_frame(8'($urandom), 8'($urandom), pick_field(), pick_field(), 1'b0,
					FRAME_BYTES);
			end else if (kind < 85) begin
				send_frame(8'($urandom), 8'($urandom), pick_field(), pick_field(), 1'b1,
					FRAME_BYTES);
			end else if (kind < 93) begin
				quiet = 1'b0;
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end else begin
				send_frame(8'($urandom), 8'($urandom), pick_field(), pick_field(), 1'b0,
					$urandom_range(1, FRAME_BYTES - 1));
			end
			// close whatever frame noise or a cut-off frame left open
			while (frame_pos != 0) send_byte(8'($urandom));
			frames++;
			if (frames % DRAIN_EVERY == 0)
				drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("[power_monitor_packet_decoder] OK");
		end else begin
			$display("[power_monitor_packet_decoder] ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[power_monitor_packet_decoder] ERROR");
		$finish;
	end

endmodule
